// ----- hdl/pss_pkg.sv -----
// Shared types and codes for the pendulum swing-up sequencer.
package pss_pkg;

    localparam int CART_W = 24;
    localparam int PEND_W = 16;
    localparam int TIME_W = 32;
    localparam int TICK_W = 31;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] MODE_HOME_LEFT  = 3'd0;
    localparam logic [2:0] MODE_HOME_RIGHT = 3'd1;
    localparam logic [2:0] MODE_TO_GOAL    = 3'd2;
    localparam logic [2:0] MODE_WIG_LEFT   = 3'd3;
    localparam logic [2:0] MODE_WIG_RIGHT  = 3'd4;
    localparam logic [2:0] MODE_WAIT       = 3'd5;
    localparam logic [2:0] MODE_IMPULSE    = 3'd6;

    localparam logic [2:0] MOT_HOLD       = 3'd0;
    localparam logic [2:0] MOT_BRAKE      = 3'd1;
    localparam logic [2:0] MOT_LEFT_SLOW  = 3'd2;
    localparam logic [2:0] MOT_RIGHT_SLOW = 3'd3;
    localparam logic [2:0] MOT_LEFT_FAST  = 3'd4;
    localparam logic [2:0] MOT_RIGHT_FAST = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_TOL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIG_INIT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIG_INC   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIG_MAX   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIG_LIMIT = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMPULSE   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PEND_WIN  = 8'd7;

    localparam logic [15:0]       RST_GOAL_TOL  = 16'd100;
    localparam logic [TICK_W-1:0] RST_WIG_INIT  = 31'd100000;
    localparam logic [TICK_W-1:0] RST_WIG_INC   = 31'd100000;
    localparam logic [TICK_W-1:0] RST_WIG_MAX   = 31'd1000000;
    localparam logic [TICK_W-1:0] RST_BRAKE     = 31'd5000;
    localparam logic [7:0]        RST_WIG_LIMIT = 8'd6;
    localparam logic [TICK_W-1:0] RST_IMPULSE   = 31'd300000;
    localparam logic [14:0]       RST_PEND_WIN  = 15'd300;

    // ceil(2^29 / 10): exact quotient for magnitudes below 2^25
    localparam logic [25:0] RECIP_TEN = 26'd53687092;
    localparam int RECIP_SHIFT = 29;

    typedef struct packed {
        logic [15:0]       goal_tol;
        logic [TICK_W-1:0] wig_init;
        logic [TICK_W-1:0] wig_inc;
        logic [TICK_W-1:0] wig_max;
        logic [TICK_W-1:0] brake;
        logic [7:0]        wig_limit;
        logic [TICK_W-1:0] impulse;
        logic [14:0]       pend_win;
    } t_cfg;

    typedef struct packed {
        logic [CART_W-1:0] left_bound;
        logic [CART_W-1:0] right_bound;
    } t_bounds;

endpackage

// ----- hdl/pss_cfg.sv -----
// Configuration register file of the swing-up sequencer.
module pss_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pss_pkg::t_cfg                     o_cfg
);

    pss_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_tol  <= pss_pkg::RST_GOAL_TOL;
            r_cfg.wig_init  <= pss_pkg::RST_WIG_INIT;
            r_cfg.wig_inc   <= pss_pkg::RST_WIG_INC;
            r_cfg.wig_max   <= pss_pkg::RST_WIG_MAX;
            r_cfg.brake     <= pss_pkg::RST_BRAKE;
            r_cfg.wig_limit <= pss_pkg::RST_WIG_LIMIT;
            r_cfg.impulse   <= pss_pkg::RST_IMPULSE;
            r_cfg.pend_win  <= pss_pkg::RST_PEND_WIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pss_pkg::REG_GOAL_TOL:  r_cfg.goal_tol  <= i_cfg_data[15:0];
                pss_pkg::REG_WIG_INIT:  r_cfg.wig_init  <= i_cfg_data[30:0];
                pss_pkg::REG_WIG_INC:   r_cfg.wig_inc   <= i_cfg_data[30:0];
                pss_pkg::REG_WIG_MAX:   r_cfg.wig_max   <= i_cfg_data[30:0];
                pss_pkg::REG_BRAKE:     r_cfg.brake     <= i_cfg_data[30:0];
                pss_pkg::REG_WIG_LIMIT: r_cfg.wig_limit <= i_cfg_data[7:0];
                pss_pkg::REG_IMPULSE:   r_cfg.impulse   <= i_cfg_data[30:0];
                pss_pkg::REG_PEND_WIN:  r_cfg.pend_win  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/pss_bounds.sv -----
// Track bounds one tenth of the wall distance in from each wall.
module pss_bounds (
    input  logic [pss_pkg::CART_W-1:0] i_left_wall,
    input  logic [pss_pkg::CART_W-1:0] i_right_wall,
    output pss_pkg::t_bounds           o_bounds
);

    logic [pss_pkg::CART_W:0]     width;
    logic [pss_pkg::CART_W:0]     mag;
    logic [50:0]                  prod;
    logic [21:0]                  quot;
    logic [pss_pkg::CART_W-1:0]   tenth;

    always_comb begin
        width = {i_right_wall[pss_pkg::CART_W-1], i_right_wall}
              - {i_left_wall[pss_pkg::CART_W-1], i_left_wall};
        mag   = width[pss_pkg::CART_W] ? (~width + 25'd1) : width;
        prod  = {26'd0, mag} * {25'd0, pss_pkg::RECIP_TEN};
        quot  = prod[pss_pkg::RECIP_SHIFT +: 22];
        // truncate toward zero: negate the magnitude quotient
        tenth = width[pss_pkg::CART_W] ? (~{2'b00, quot} + 24'd1) : {2'b00, quot};
        o_bounds.left_bound  = i_left_wall + tenth;
        o_bounds.right_bound = i_right_wall - tenth;
    end

endmodule

// ----- hdl/pendulum_swing_up_sequencer.sv -----
// Top level of the pendulum swing-up sequencer: request registers, mode logic, result register.
// A request is registered on acceptance and its result loads into the result register when it advances.
// Throughput: one request per cycle while the output is not stalled; the mode logic updates all state in the same
// cycle the result register loads, so each request sees the state left by the last.
// Reset: synchronous, active low; mode homing left, walls, goal and timing marks zero,
// wiggle duration and configuration registers at their defaults, both stages empty.
module pendulum_swing_up_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [pss_pkg::TIME_W-1:0]           i_timer_now,
    input  logic                                 i_left_switch,
    input  logic                                 i_right_switch,
    input  logic signed [pss_pkg::CART_W-1:0]    i_cart_position,
    input  logic signed [pss_pkg::PEND_W-1:0]    i_pendulum_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [2:0]                           o_mode,
    output logic [2:0]                           o_motor_command,
    output logic                                 o_bounds_valid,
    output logic signed [pss_pkg::CART_W-1:0]    o_left_bound,
    output logic signed [pss_pkg::CART_W-1:0]    o_right_bound,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    pss_pkg::t_cfg    cfg;
    pss_pkg::t_bounds bounds;

    logic                          r_in_vld;
    logic [pss_pkg::TIME_W-1:0]    r_in_now;
    logic                          r_in_lsw;
    logic                          r_in_rsw;
    logic [pss_pkg::CART_W-1:0]    r_in_cart;
    logic [pss_pkg::PEND_W-1:0]    r_in_pend;

    logic                          r_out_vld;
    logic [2:0]                    r_out_mode;
    logic [2:0]                    r_out_motor;
    logic                          r_out_bval;
    logic [pss_pkg::CART_W-1:0]    r_out_lb;
    logic [pss_pkg::CART_W-1:0]    r_out_rb;

    logic [2:0]                    r_mode, n_mode;
    logic [pss_pkg::CART_W-1:0]    r_left, n_left;
    logic [pss_pkg::CART_W-1:0]    r_right, n_right;
    logic [pss_pkg::CART_W-1:0]    r_goal, n_goal;
    logic [pss_pkg::TIME_W-1:0]    r_wig_start, n_wig_start;
    logic [pss_pkg::TICK_W-1:0]    r_wig_dur, n_wig_dur;
    logic [7:0]                    r_wig_done, n_wig_done;
    logic [pss_pkg::TIME_W-1:0]    r_imp_start, n_imp_start;
    logic                          r_imp_left, n_imp_left;

    logic [2:0]                    motor;
    logic                          bval;
    logic                          adv;
    logic                          in_take;

    logic [pss_pkg::CART_W:0]      goal_sum;
    logic [pss_pkg::CART_W:0]      goal_adj;
    logic [pss_pkg::CART_W:0]      goal_err;
    logic [pss_pkg::CART_W:0]      goal_dist;
    logic [pss_pkg::TIME_W-1:0]    wig_elapsed;
    logic [pss_pkg::TIME_W-1:0]    brake_end;
    logic [pss_pkg::TIME_W-1:0]    dur_sum;
    logic [pss_pkg::TIME_W-1:0]    imp_elapsed;
    logic [pss_pkg::PEND_W:0]      pend_mag;

    pss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pss_bounds u_bounds (
        .i_left_wall  (r_left),
        .i_right_wall (r_right),
        .o_bounds     (bounds)
    );

    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign in_take    = !r_in_vld || adv;
    assign o_in_stall = !in_take;

    assign o_out_valid     = r_out_vld;
    assign o_mode          = r_out_mode;
    assign o_motor_command = r_out_motor;
    assign o_bounds_valid  = r_out_bval;
    assign o_left_bound    = r_out_lb;
    assign o_right_bound   = r_out_rb;

    always_comb begin
        goal_sum    = {r_left[pss_pkg::CART_W-1], r_left}
                    + {r_in_cart[pss_pkg::CART_W-1], r_in_cart};
        goal_adj    = goal_sum + {24'd0, goal_sum[pss_pkg::CART_W]};
        goal_err    = {r_in_cart[pss_pkg::CART_W-1], r_in_cart}
                    - {r_goal[pss_pkg::CART_W-1], r_goal};
        goal_dist   = goal_err[pss_pkg::CART_W] ? (~goal_err + 25'd1) : goal_err;
        wig_elapsed = r_in_now - r_wig_start;
        brake_end   = {1'b0, r_wig_dur} + {1'b0, cfg.brake};
        dur_sum     = {1'b0, r_wig_dur} + {1'b0, cfg.wig_inc};
        imp_elapsed = r_in_now - r_imp_start;
        pend_mag    = r_in_pend[pss_pkg::PEND_W-1]
                    ? (~{1'b1, r_in_pend} + 17'd1) : {1'b0, r_in_pend};

        n_mode      = r_mode;
        n_left      = r_left;
        n_right     = r_right;
        n_goal      = r_goal;
        n_wig_start = r_wig_start;
        n_wig_dur   = r_wig_dur;
        n_wig_done  = r_wig_done;
        n_imp_start = r_imp_start;
        n_imp_left  = r_imp_left;
        motor       = pss_pkg::MOT_HOLD;
        bval        = 1'b0;

        case (r_mode)
            pss_pkg::MODE_HOME_RIGHT: begin
                if (r_in_rsw) begin
                    n_right = r_in_cart;
                    n_goal  = goal_adj[pss_pkg::CART_W:1];
                    n_mode  = pss_pkg::MODE_TO_GOAL;
                end else begin
                    motor = pss_pkg::MOT_RIGHT_SLOW;
                end
            end
            pss_pkg::MODE_TO_GOAL: begin
                if (goal_dist <= {9'd0, cfg.goal_tol}) begin
                    bval        = 1'b1;
                    n_wig_start = r_in_now;
                    n_wig_dur   = cfg.wig_init;
                    n_mode      = pss_pkg::MODE_WIG_LEFT;
                end else if ($signed(r_in_cart) < $signed(r_goal)) begin
                    motor = pss_pkg::MOT_RIGHT_SLOW;
                end else begin
                    motor = pss_pkg::MOT_LEFT_SLOW;
                end
            end
            pss_pkg::MODE_WIG_LEFT, pss_pkg::MODE_WIG_RIGHT: begin
                if (r_wig_done >= cfg.wig_limit) begin
                    n_mode = pss_pkg::MODE_WAIT;
                end else if (wig_elapsed < {1'b0, r_wig_dur}) begin
                    motor = (r_mode == pss_pkg::MODE_WIG_LEFT)
                          ? pss_pkg::MOT_LEFT_FAST : pss_pkg::MOT_RIGHT_FAST;
                end else if (wig_elapsed < brake_end) begin
                    motor = pss_pkg::MOT_BRAKE;
                end else begin
                    n_wig_start = r_in_now;
                    if (r_mode == pss_pkg::MODE_WIG_LEFT) begin
                        n_mode = pss_pkg::MODE_WIG_RIGHT;
                    end else begin
                        if (r_wig_done != 8'hFF) begin
                            n_wig_done = r_wig_done + 8'd1;
                        end
                        n_wig_dur = (dur_sum > {1'b0, cfg.wig_max})
                                  ? cfg.wig_max : dur_sum[pss_pkg::TICK_W-1:0];
                        n_mode = pss_pkg::MODE_WIG_LEFT;
                    end
                end
            end
            pss_pkg::MODE_WAIT: begin
                motor = pss_pkg::MOT_BRAKE;
                if (pend_mag < {2'b00, cfg.pend_win}) begin
                    n_imp_start = r_in_now;
                    n_imp_left  = !r_in_pend[pss_pkg::PEND_W-1];
                    n_mode      = pss_pkg::MODE_IMPULSE;
                end
            end
            pss_pkg::MODE_IMPULSE: begin
                if (imp_elapsed > {1'b0, cfg.impulse}) begin
                    n_mode = pss_pkg::MODE_WAIT;
                end else begin
                    motor = r_imp_left ? pss_pkg::MOT_LEFT_FAST : pss_pkg::MOT_RIGHT_FAST;
                end
            end
            default: begin
                if (r_in_lsw) begin
                    n_left = r_in_cart;
                    n_mode = pss_pkg::MODE_HOME_RIGHT;
                end else begin
                    n_mode = pss_pkg::MODE_HOME_LEFT;
                    motor  = pss_pkg::MOT_LEFT_SLOW;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_mode      <= pss_pkg::MODE_HOME_LEFT;
            r_left      <= '0;
            r_right     <= '0;
            r_goal      <= '0;
            r_wig_start <= '0;
            r_wig_dur   <= pss_pkg::RST_WIG_INIT;
            r_wig_done  <= '0;
            r_imp_start <= '0;
            r_imp_left  <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld   <= 1'b1;
                r_mode      <= n_mode;
                r_left      <= n_left;
                r_right     <= n_right;
                r_goal      <= n_goal;
                r_wig_start <= n_wig_start;
                r_wig_dur   <= n_wig_dur;
                r_wig_done  <= n_wig_done;
                r_imp_start <= n_imp_start;
                r_imp_left  <= n_imp_left;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in_now  <= i_timer_now;
            r_in_lsw  <= i_left_switch;
            r_in_rsw  <= i_right_switch;
            r_in_cart <= i_cart_position;
            r_in_pend <= i_pendulum_position;
        end
        if (adv) begin
            r_out_mode  <= n_mode;
            r_out_motor <= motor;
            r_out_bval  <= bval;
            r_out_lb    <= bval ? bounds.left_bound : '0;
            r_out_rb    <= bval ? bounds.right_bound : '0;
        end
    end

    a_bounds_in_wiggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_bval) |-> (r_out_mode == pss_pkg::MODE_WIG_LEFT))
        else $error("bounds reported outside the entry into wiggling");

    a_bounds_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_bval) |-> (r_out_lb == '0 && r_out_rb == '0))
        else $error("bounds not cleared while not valid");

    a_request_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && i_out_stall) |=> r_in_vld)
        else $error("buffered request dropped under stall");

    a_wiggle_count_grows: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_wig_done >= $past(r_wig_done)))
        else $error("wiggle count decreased");

endmodule

// ----- sim/pendulum_swing_up_sequencer_tb.sv -----
// Self-checking testbench for the pendulum swing-up sequencer with an in-line mode predictor.
module pendulum_swing_up_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pss_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd200;
    localparam logic signed [pss_pkg::CART_W-1:0] CART_MIN = 24'sh800000;
    localparam logic signed [pss_pkg::CART_W-1:0] CART_MAX = 24'sh7FFFFF;
    localparam logic signed [pss_pkg::PEND_W-1:0] PEND_MIN = 16'sh8000;
    localparam logic signed [pss_pkg::PEND_W-1:0] PEND_MAX = 16'sh7FFF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [pss_pkg::TIME_W-1:0]        timer;
        logic                              lsw;
        logic                              rsw;
        logic signed [pss_pkg::CART_W-1:0] cart;
        logic signed [pss_pkg::PEND_W-1:0] pend;
    } t_tick;

    typedef struct packed {
        logic [2:0]                 mode;
        logic [2:0]                 motor;
        logic                       bvalid;
        logic [pss_pkg::CART_W-1:0] lb;
        logic [pss_pkg::CART_W-1:0] rb;
    } t_cmd;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [pss_pkg::TIME_W-1:0] in_timer = '0;
    logic in_lsw = 1'b0;
    logic in_rsw = 1'b0;
    logic signed [pss_pkg::CART_W-1:0] in_cart = '0;
    logic signed [pss_pkg::PEND_W-1:0] in_pend = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [pss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic o_in_stall;
    logic o_out_valid;
    logic [2:0] o_mode;
    logic [2:0] o_motor_command;
    logic o_bounds_valid;
    logic signed [pss_pkg::CART_W-1:0] o_left_bound;
    logic signed [pss_pkg::CART_W-1:0] o_right_bound;
    logic o_cfg_ready;

    pss_pkg::t_cfg cfg_shadow;
    logic [2:0] seq_mode;
    int left_wall;
    int right_wall;
    int goal;
    logic [pss_pkg::TIME_W-1:0] wig_start;
    logic [pss_pkg::TIME_W-1:0] imp_start;
    logic [pss_pkg::TICK_W-1:0] wig_len;
    logic [7:0] wig_count;
    logic imp_left;

    t_tick tick_queue[$];
    t_cmd expected_cmds[$];
    t_tick cur_tick;
    t_cmd want;
    t_cmd got;
    logic [pss_pkg::TIME_W-1:0] stamp;
    int gap_left = 0;
    int stall_left = 0;
    int idle_odds = 0;
    int mismatches = 0;
    int cycle_count = 0;

    pendulum_swing_up_sequencer u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (o_in_stall),
        .i_timer_now         (in_timer),
        .i_left_switch       (in_lsw),
        .i_right_switch      (in_rsw),
        .i_cart_position     (in_cart),
        .i_pendulum_position (in_pend),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (out_stall),
        .o_mode              (o_mode),
        .o_motor_command     (o_motor_command),
        .o_bounds_valid      (o_bounds_valid),
        .o_left_bound        (o_left_bound),
        .o_right_bound       (o_right_bound),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic step_sequencer(input t_tick t);
        t_cmd c;
        int cart;
        int pend;
        int d;
        int tenth;
        int mag;
        logic [pss_pkg::TIME_W-1:0] el;
        logic [pss_pkg::TIME_W:0] nd;
        cart = int'(t.cart);
        pend = int'(t.pend);
        c = '0;
        c.mode = seq_mode;
        c.motor = pss_pkg::MOT_HOLD;
        case (seq_mode)
            pss_pkg::MODE_HOME_RIGHT: begin
                if (t.rsw) begin
                    right_wall = cart;
                    goal = (left_wall + right_wall) / 2;
                    c.mode = pss_pkg::MODE_TO_GOAL;
                end else begin
                    c.motor = pss_pkg::MOT_RIGHT_SLOW;
                end
            end
            pss_pkg::MODE_TO_GOAL: begin
                d = cart - goal;
                if (d < 0) d = -d;
                if (d <= int'(cfg_shadow.goal_tol)) begin
                    tenth = (right_wall - left_wall) / 10;
                    c.lb = pss_pkg::CART_W'(left_wall + tenth);
                    c.rb = pss_pkg::CART_W'(right_wall - tenth);
                    c.bvalid = 1'b1;
                    wig_start = t.timer;
                    wig_len = cfg_shadow.wig_init;
                    c.mode = pss_pkg::MODE_WIG_LEFT;
                end else if (cart < goal) begin
                    c.motor = pss_pkg::MOT_RIGHT_SLOW;
                end else begin
                    c.motor = pss_pkg::MOT_LEFT_SLOW;
                end
            end
            pss_pkg::MODE_WIG_LEFT, pss_pkg::MODE_WIG_RIGHT: begin
                if (wig_count >= cfg_shadow.wig_limit) begin
                    c.mode = pss_pkg::MODE_WAIT;
                end else begin
                    el = t.timer - wig_start;
                    if (el < {1'b0, wig_len}) begin
                        c.motor = (seq_mode == pss_pkg::MODE_WIG_LEFT)
                                ? pss_pkg::MOT_LEFT_FAST : pss_pkg::MOT_RIGHT_FAST;
                    end else if ({1'b0, el} < {2'b00, wig_len} + {2'b00, cfg_shadow.brake}) begin
                        c.motor = pss_pkg::MOT_BRAKE;
                    end else begin
                        wig_start = t.timer;
                        if (seq_mode == pss_pkg::MODE_WIG_LEFT) begin
                            c.mode = pss_pkg::MODE_WIG_RIGHT;
                        end else begin
                            nd = {2'b00, wig_len} + {2'b00, cfg_shadow.wig_inc};
                            if (wig_count != 8'hFF) wig_count = wig_count + 8'd1;
                            if (nd > {2'b00, cfg_shadow.wig_max}) begin
                                nd = {2'b00, cfg_shadow.wig_max};
                            end
                            wig_len = nd[pss_pkg::TICK_W-1:0];
                            c.mode = pss_pkg::MODE_WIG_LEFT;
                        end
                    end
                end
            end
            pss_pkg::MODE_WAIT: begin
                mag = (pend < 0) ? -pend : pend;
                c.motor = pss_pkg::MOT_BRAKE;
                if (mag < int'(cfg_shadow.pend_win)) begin
                    imp_start = t.timer;
                    imp_left = (pend >= 0);
                    c.mode = pss_pkg::MODE_IMPULSE;
                end
            end
            pss_pkg::MODE_IMPULSE: begin
                el = t.timer - imp_start;
                if (el > {1'b0, cfg_shadow.impulse}) begin
                    c.mode = pss_pkg::MODE_WAIT;
                end else begin
                    c.motor = imp_left ? pss_pkg::MOT_LEFT_FAST : pss_pkg::MOT_RIGHT_FAST;
                end
            end
            default: begin
                if (t.lsw) begin
                    left_wall = cart;
                    c.mode = pss_pkg::MODE_HOME_RIGHT;
                end else begin
                    c.mode = pss_pkg::MODE_HOME_LEFT;
                    c.motor = pss_pkg::MOT_LEFT_SLOW;
                end
            end
        endcase
        seq_mode = c.mode;
        expected_cmds.push_back(c);
    endtask

    task automatic push_tick(input logic lsw, input logic rsw,
                             input logic signed [pss_pkg::CART_W-1:0] cart,
                             input logic signed [pss_pkg::PEND_W-1:0] pend);
        t_tick t;
        t.timer = stamp;
        t.lsw = lsw;
        t.rsw = rsw;
        t.cart = cart;
        t.pend = pend;
        tick_queue.push_back(t);
    endtask

    task automatic add_random_ticks(input int n, input int step, input int jump_odds);
        repeat (n) begin
            if (jump_odds != 0 && $urandom_range(jump_odds - 1) == 0) begin
                stamp = $urandom();
            end else begin
                stamp = stamp + $urandom_range(step);
            end
            push_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                      pss_pkg::CART_W'($urandom()),
                      pss_pkg::PEND_W'($urandom_range(1) ? ($urandom_range(600) - 300)
                                                         : $urandom()));
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (tick_queue.size() != 0 || in_valid || expected_cmds.size() != 0);
    endtask

    task automatic write_reg(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pss_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pss_pkg::REG_GOAL_TOL:  cfg_shadow.goal_tol = val[15:0];
            pss_pkg::REG_WIG_INIT:  cfg_shadow.wig_init = val[pss_pkg::TICK_W-1:0];
            pss_pkg::REG_WIG_INC:   cfg_shadow.wig_inc = val[pss_pkg::TICK_W-1:0];
            pss_pkg::REG_WIG_MAX:   cfg_shadow.wig_max = val[pss_pkg::TICK_W-1:0];
            pss_pkg::REG_BRAKE:     cfg_shadow.brake = val[pss_pkg::TICK_W-1:0];
            pss_pkg::REG_WIG_LIMIT: cfg_shadow.wig_limit = val[7:0];
            pss_pkg::REG_IMPULSE:   cfg_shadow.impulse = val[pss_pkg::TICK_W-1:0];
            pss_pkg::REG_PEND_WIN:  cfg_shadow.pend_win = val[14:0];
            default: ;
        endcase
    endtask

    task automatic wiggle_phase(input logic [31:0] inc, input logic [31:0] top,
                                input logic [31:0] brake, input int step,
                                input int jump_odds, input int odds);
        write_reg(pss_pkg::REG_WIG_INC, inc);
        write_reg(pss_pkg::REG_WIG_MAX, top);
        write_reg(pss_pkg::REG_BRAKE, brake);
        idle_odds = odds;
        add_random_ticks(120, step, jump_odds);
        wait_drained();
    endtask

    task automatic wait_phase(input logic [31:0] win, input logic [31:0] imp, input int n,
                              input int step, input int jump_odds, input int odds);
        write_reg(pss_pkg::REG_PEND_WIN, win);
        write_reg(pss_pkg::REG_IMPULSE, imp);
        idle_odds = odds;
        add_random_ticks(n, step, jump_odds);
        wait_drained();
    endtask

    // driver: present requests, hold while stalled, insert idle bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall) step_sequencer(cur_tick);
            if (in_valid && o_in_stall) begin
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (tick_queue.size() > 0 && idle_odds != 0 &&
                         $urandom_range(idle_odds - 1) == 0) begin
                gap_left = int'($urandom_range(11));
                in_valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                cur_tick = tick_queue.pop_front();
                in_valid <= 1'b1;
                in_timer <= cur_tick.timer;
                in_lsw <= cur_tick.lsw;
                in_rsw <= cur_tick.rsw;
                in_cart <= cur_tick.cart;
                in_pend <= cur_tick.pend;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result against the oldest prediction, stall in bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got.mode = o_mode;
                got.motor = o_motor_command;
                got.bvalid = o_bounds_valid;
                got.lb = o_left_bound;
                got.rb = o_right_bound;
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: mode %0d motor %0d", got.mode, got.motor);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"mismatch mode/motor/bounds: expected %0d %0d %0b %0d %0d,",
                                      " got %0d %0d %0b %0d %0d"},
                                     want.mode, want.motor, want.bvalid, $signed(want.lb),
                                     $signed(want.rb), got.mode, got.motor, got.bvalid,
                                     $signed(got.lb), $signed(got.rb));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
                stall_left = int'($urandom_range(11));
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        cfg_shadow = '{pss_pkg::RST_GOAL_TOL, pss_pkg::RST_WIG_INIT, pss_pkg::RST_WIG_INC,
                       pss_pkg::RST_WIG_MAX, pss_pkg::RST_BRAKE, pss_pkg::RST_WIG_LIMIT,
                       pss_pkg::RST_IMPULSE, pss_pkg::RST_PEND_WIN};
        seq_mode = pss_pkg::MODE_HOME_LEFT;
        left_wall = 0;
        right_wall = 0;
        goal = 0;
        wig_start = '0;
        imp_start = '0;
        wig_len = pss_pkg::RST_WIG_INIT;
        wig_count = '0;
        imp_left = 1'b0;
        stamp = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(pss_pkg::REG_GOAL_TOL, 32'd0);
        write_reg(pss_pkg::REG_WIG_INIT, 32'h7FFF_FFFF);
        write_reg(pss_pkg::REG_WIG_INC, 32'd25);
        write_reg(pss_pkg::REG_WIG_MAX, 32'd150);
        write_reg(pss_pkg::REG_BRAKE, 32'd12);
        write_reg(pss_pkg::REG_WIG_LIMIT, 32'd255);
        write_reg(pss_pkg::REG_IMPULSE, 32'd40);
        write_reg(pss_pkg::REG_PEND_WIN, 32'd300);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);

        // homing to both walls, then approach a goal of zero with zero tolerance
        idle_odds = 3;
        stamp = 32'h0000_0000; push_tick(1'b0, 1'b0, 24'sd0, 16'sd0);
        stamp = 32'hFFFF_FFFF; push_tick(1'b0, 1'b1, CART_MAX, PEND_MAX);
        stamp = 32'd1; push_tick(1'b0, 1'b0, CART_MIN, PEND_MIN);
        stamp = 32'd2; push_tick(1'b1, 1'b0, CART_MIN, 16'sd0);
        stamp = 32'd3; push_tick(1'b1, 1'b0, 24'sd0, 16'sd0);
        stamp = 32'd4; push_tick(1'b0, 1'b0, 24'sd0, 16'sd0);
        stamp = 32'd5; push_tick(1'b0, 1'b1, CART_MAX, 16'sd0);
        stamp = 32'd6; push_tick(1'b0, 1'b0, 24'sd1, 16'sd0);
        stamp = 32'd7; push_tick(1'b1, 1'b1, -24'sd1, 16'sd0);
        stamp = 32'd8; push_tick(1'b0, 1'b0, CART_MIN, 16'sd0);
        stamp = 32'd9; push_tick(1'b0, 1'b0, CART_MAX, 16'sd0);
        wait_drained();

        write_reg(pss_pkg::REG_GOAL_TOL, 32'hFFFF_FFFF);
        write_reg(pss_pkg::REG_WIG_INIT, 32'd0);
        stamp = 32'd10; push_tick(1'b0, 1'b0, 24'sd65536, 16'sd0);
        stamp = 32'd11; push_tick(1'b0, 1'b0, -24'sd65536, 16'sd0);
        stamp = 32'hFFFF_FF00; push_tick(1'b0, 1'b0, -24'sd65535, 16'sd0);
        wait_drained();

        wiggle_phase(32'd25, 32'd150, 32'd12, 10, 40, 6);
        wiggle_phase(32'd0, 32'h7FFF_FFFF, 32'd0, 10, 40, 0);
        wiggle_phase(32'h7FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 0, 1, 3);
        wiggle_phase(32'd5, 32'd0, 32'd8, 6, 15, 10);
        write_reg(pss_pkg::REG_WIG_LIMIT, {24'd0, wig_count + 8'd1});
        wiggle_phase(32'd10, 32'd80, 32'd3, 10, 30, 5);
        write_reg(pss_pkg::REG_WIG_LIMIT, 32'd0);

        // settle in wait, then window edges and impulse timing
        idle_odds = 4;
        stamp = stamp + 32'd1000; push_tick(1'b0, 1'b0, 24'sd0, PEND_MIN);
        stamp = stamp + 32'd1; push_tick(1'b0, 1'b0, 24'sd0, PEND_MIN);
        stamp = stamp + 32'd1; push_tick(1'b0, 1'b0, 24'sd0, 16'sd300);
        stamp = stamp + 32'd1; push_tick(1'b0, 1'b0, 24'sd0, -16'sd300);
        stamp = stamp + 32'd1; push_tick(1'b0, 1'b0, 24'sd0, -16'sd299);
        stamp = stamp + 32'd40; push_tick(1'b0, 1'b0, 24'sd0, 16'sd0);
        stamp = stamp + 32'd1; push_tick(1'b0, 1'b0, 24'sd0, 16'sd0);
        stamp = stamp + 32'd1; push_tick(1'b0, 1'b0, 24'sd0, 16'sd0);
        stamp = stamp + 32'd20; push_tick(1'b0, 1'b0, 24'sd0, PEND_MAX);
        stamp = stamp + 32'd21; push_tick(1'b0, 1'b0, 24'sd0, PEND_MAX);
        add_random_ticks(140, 8, 40);
        wait_drained();

        wait_phase(32'd0, 32'd0, 60, 4, 0, 0);
        wait_phase(32'd32767, 32'h7FFF_FFFF, 150, 0, 1, 4);
        wait_phase(32'd100, 32'd0, 150, 2, 0, 8);
        wait_phase(32'd2000, 32'd25, 200, 6, 50, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_cmds.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
